FILE: design/owr_pkg.sv
// Shared types, constants and sequencing functions for the one-wire temperature reader.
// Used by owr_core, onewire_temperature_reader_unit and tb_top; depends on nothing else.
`default_nettype none

package owr_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRESENCE_SAMP = 3'd1;
	localparam logic [2:0] REG_RESET_REC     = 3'd2;
	localparam logic [2:0] REG_SLOT          = 3'd3;
	localparam logic [2:0] REG_ZERO_REC      = 3'd4;
	localparam logic [2:0] REG_CONV_WAIT     = 3'd5;

	// Bus commands.
	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

	// Bound on the number of empty phases passed over in one word. The longest
	// possible run through the fixed script is seven.
	localparam int SettleSteps = 10;

	typedef enum logic [17:0] {
		PH_IDLE      = 18'h00001,
		PH_RST1_LOW  = 18'h00002,
		PH_RST1_WAIT = 18'h00004,
		PH_RST1_REC  = 18'h00008,
		PH_CC1_LOW   = 18'h00010,
		PH_CC1_REL   = 18'h00020,
		PH_CNV_LOW   = 18'h00040,
		PH_CNV_REL   = 18'h00080,
		PH_CONV_WAIT = 18'h00100,
		PH_RST2_LOW  = 18'h00200,
		PH_RST2_WAIT = 18'h00400,
		PH_RST2_REC  = 18'h00800,
		PH_CC2_LOW   = 18'h01000,
		PH_CC2_REL   = 18'h02000,
		PH_BE_LOW    = 18'h04000,
		PH_BE_REL    = 18'h08000,
		PH_RX_LOW    = 18'h10000,
		PH_RX_REL    = 18'h20000
	} phase_t;

	typedef struct packed {
		logic [11:0] reset_low_ticks;
		logic [11:0] presence_sample_ticks;
		logic [11:0] reset_recovery_ticks;
		logic [7:0]  slot_ticks;
		logic [7:0]  zero_recovery_ticks;
		logic [19:0] conversion_wait_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [19:0] tick;
		logic [3:0]  bidx;
		logic [7:0]  cmd;
		logic [15:0] rd;
		logic        pres;
		logic        fin;
	} st_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy;
		logic        done;
		logic        presence;
		logic [15:0] raw;
	} res_t;

	// Length in ticks of a phase; command phases depend on the bit being sent.
	function automatic logic [19:0] phase_len(phase_t p, logic one, cfg_t c);
		logic [19:0] len;
		unique case (p)
			PH_RST1_LOW, PH_RST2_LOW:   len = 20'(c.reset_low_ticks);
			PH_RST1_WAIT, PH_RST2_WAIT:
				len = (c.presence_sample_ticks == 12'd0) ? 20'd1
					: 20'(c.presence_sample_ticks);
			PH_RST1_REC, PH_RST2_REC:   len = 20'(c.reset_recovery_ticks);
			PH_CC1_LOW, PH_CNV_LOW, PH_CC2_LOW, PH_BE_LOW:
				len = one ? 20'd1 : 20'(c.slot_ticks);
			PH_CC1_REL, PH_CNV_REL, PH_CC2_REL, PH_BE_REL:
				len = one ? 20'(c.slot_ticks) : 20'(c.zero_recovery_ticks);
			PH_CONV_WAIT:               len = c.conversion_wait_ticks;
			PH_RX_LOW:                  len = 20'd1;
			PH_RX_REL:                  len = 20'(c.slot_ticks) + 20'd1;
			default:                    len = 20'd1;
		endcase
		return len;
	endfunction

	// Leave the current phase and enter the next one of the script.
	function automatic st_t advance(st_t s, logic level);
		st_t n;
		logic [3:0] nb;
		n = s;
		nb = s.bidx + 4'd1;
		unique case (s.phase)
			PH_RST1_WAIT: begin
				n.pres = level;
				n.phase = PH_RST1_REC;
			end
			PH_RST2_WAIT: begin
				n.pres = level;
				n.phase = PH_RST2_REC;
			end
			PH_RST1_REC, PH_RST2_REC: begin
				n.cmd = CMD_SKIP_ROM;
				n.bidx = 4'd0;
				n.phase = (s.phase == PH_RST1_REC) ? PH_CC1_LOW : PH_CC2_LOW;
			end
			PH_CC1_REL, PH_CNV_REL, PH_CC2_REL, PH_BE_REL: begin
				n.cmd = {1'b0, s.cmd[7:1]};
				n.bidx = nb;
				if (nb != 4'd8) begin
					unique case (s.phase)
						PH_CC1_REL: n.phase = PH_CC1_LOW;
						PH_CNV_REL: n.phase = PH_CNV_LOW;
						PH_CC2_REL: n.phase = PH_CC2_LOW;
						default:    n.phase = PH_BE_LOW;
					endcase
				end else begin
					n.bidx = 4'd0;
					unique case (s.phase)
						PH_CC1_REL: begin
							n.cmd = CMD_CONVERT;
							n.phase = PH_CNV_LOW;
						end
						PH_CNV_REL: n.phase = PH_CONV_WAIT;
						PH_CC2_REL: begin
							n.cmd = CMD_READ_PAD;
							n.phase = PH_BE_LOW;
						end
						default: begin
							n.rd = 16'd0;
							n.phase = PH_RX_LOW;
						end
					endcase
				end
			end
			PH_CONV_WAIT: n.phase = PH_RST2_LOW;
			PH_RX_REL: begin
				if (s.bidx == 4'd15) begin
					n.fin = 1'b1;
					n.phase = PH_IDLE;
				end else begin
					n.bidx = nb;
					n.phase = PH_RX_LOW;
				end
			end
			PH_RST1_LOW: n.phase = PH_RST1_WAIT;
			PH_CC1_LOW:  n.phase = PH_CC1_REL;
			PH_CNV_LOW:  n.phase = PH_CNV_REL;
			PH_RST2_LOW: n.phase = PH_RST2_WAIT;
			PH_CC2_LOW:  n.phase = PH_CC2_REL;
			PH_BE_LOW:   n.phase = PH_BE_REL;
			PH_RX_LOW:   n.phase = PH_RX_REL;
			default:     n.phase = PH_IDLE;
		endcase
		n.tick = 20'd0;
		return n;
	endfunction

	// Pass over every phase of zero length that follows.
	function automatic st_t settle(st_t s, logic level, cfg_t c);
		st_t n;
		n = s;
		for (int i = 0; i < SettleSteps; i++) begin
			if (n.phase != PH_IDLE && phase_len(n.phase, n.cmd[0], c) == 20'd0) begin
				n = advance(n, level);
			end
		end
		return n;
	endfunction

	function automatic logic drive_of(phase_t p);
		logic d;
		unique case (p)
			PH_RST1_LOW, PH_RST2_LOW, PH_CC1_LOW, PH_CNV_LOW,
			PH_CC2_LOW, PH_BE_LOW, PH_RX_LOW: d = 1'b1;
			default:                          d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: design/owr_core.sv
// Sequencer state and per-tick step logic of the one-wire temperature reader.
// Depends on owr_pkg.
`default_nettype none

module owr_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  op,
	input  wire                  level,
	input  wire owr_pkg::cfg_t   cfg,
	output owr_pkg::res_t        res
);
	import owr_pkg::*;

	st_t st_q;
	st_t nx;
	st_t ticked;

	always_comb begin
		nx = st_q;
		nx.fin = 1'b0;
		ticked = nx;
		if (op) begin
			if (st_q.phase == PH_IDLE) begin
				ticked.phase = PH_RST1_LOW;
				ticked.tick = 20'd0;
				nx = settle(ticked, level, cfg);
			end
		end else if (st_q.phase != PH_IDLE) begin
			// The read bit is the level on the first released tick of a slot.
			if (st_q.phase == PH_RX_REL && st_q.tick == 20'd0) begin
				ticked.rd[st_q.bidx] = st_q.rd[st_q.bidx] | level;
			end
			ticked.tick = st_q.tick + 20'd1;
			if (ticked.tick >= phase_len(st_q.phase, st_q.cmd[0], cfg)) begin
				nx = settle(advance(ticked, level), level, cfg);
			end else begin
				nx = ticked;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.tick  <= 20'd0;
			st_q.bidx  <= 4'd0;
			st_q.cmd   <= 8'd0;
			st_q.rd    <= 16'd0;
			st_q.pres  <= 1'b0;
			st_q.fin   <= 1'b0;
		end else if (en) begin
			st_q <= nx;
		end
	end

	assign res.drive_low = drive_of(nx.phase);
	assign res.busy      = (nx.phase != PH_IDLE);
	assign res.done      = nx.fin;
	assign res.presence  = nx.pres;
	assign res.raw       = nx.rd;

endmodule

`default_nettype wire

FILE: design/onewire_temperature_reader_unit.sv
// Top level of the one-wire temperature reader: stream ports, configuration
// registers, input register and result register. Depends on owr_pkg and owr_core.
`default_nettype none

// Path: a word accepted into the input register is stepped when the result register can
// take its result, which is then captured there (two register stages).
// Throughput: one word per cycle unless stalled; input and result registers
// let a new word in while a finished result still waits on the master side.
// Reset: arst_n clears the sequencer to idle, both valid flags, and loads the
// configuration registers with their default timings.
module onewire_temperature_reader_unit (
	input  wire         clk,
	input  wire         arst_n,
	// Input stream.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  wire  [0:0]  s_tuser,   // [0] op: 0 tick, 1 start
	// Result stream.
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [3] presence_seen, [19:4] raw_reading,
	                               // [35:20] temperature_centi, [39:36] zero
	// Configuration write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [19:0] cfg_data
);
	import owr_pkg::*;

	cfg_t cfg_q;

	logic valid_s1;
	logic op_s1;
	logic level_s1;

	logic out_free;
	logic step_en;
	res_t res;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks       <= 12'd500;
			cfg_q.presence_sample_ticks <= 12'd30;
			cfg_q.reset_recovery_ticks  <= 12'd500;
			cfg_q.slot_ticks            <= 8'd80;
			cfg_q.zero_recovery_ticks   <= 8'd8;
			cfg_q.conversion_wait_ticks <= 20'd800000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESET_LOW:     cfg_q.reset_low_ticks       <= cfg_data[11:0];
				REG_PRESENCE_SAMP: cfg_q.presence_sample_ticks <= cfg_data[11:0];
				REG_RESET_REC:     cfg_q.reset_recovery_ticks  <= cfg_data[11:0];
				REG_SLOT:          cfg_q.slot_ticks            <= cfg_data[7:0];
				REG_ZERO_REC:      cfg_q.zero_recovery_ticks   <= cfg_data[7:0];
				REG_CONV_WAIT:     cfg_q.conversion_wait_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held word is stepped whenever the result register can take its
	// result, and the input register refills in the same cycle.
	assign out_free = !m_tvalid || m_tready;
	assign step_en  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser[0];
			level_s1 <= s_tdata[0];
		end
	end

	owr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.op     (op_s1),
		.level  (level_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Hundredths of a degree: raw*100/16, rounded toward zero. The product
	// raw*100 is built from shifted copies and fits in 24 bits signed.
	logic signed [23:0] raw_ext;
	logic signed [23:0] prod;
	logic signed [23:0] biased;
	logic        [15:0] centi;

	always_comb begin
		raw_ext = 24'(signed'(res.raw));
		prod    = (raw_ext <<< 6) + (raw_ext <<< 5) + (raw_ext <<< 2);
		biased  = prod + (prod[23] ? 24'sd15 : 24'sd0);
		centi   = biased[19:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (step_en) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			m_tdata <= {4'd0,
				res.done ? centi : 16'd0,
				res.done ? res.raw : 16'd0,
				res.presence, res.done, res.busy, res.drive_low};
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for onewire_temperature_reader_unit: random stream traffic,
// a cycle-level model of the bus sequencer and a word-by-word result check.
// Depends on owr_pkg and the unit under test only.
`timescale 1ns / 100ps

module tb_top;
	import owr_pkg::*;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_START = 1'b1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int CHUNK = 16;
	localparam int HOLDOFF_CYCLES = 300;

	// How the sensor side of the bus behaves while a batch of ticks is sent.
	typedef enum int {
		LEVEL_LOW,
		LEVEL_HIGH,
		LEVEL_RANDOM,
		LEVEL_MOSTLY_HIGH,
		LEVEL_MIXED
	} level_mode_t;

	typedef struct packed {
		logic op;
		logic level;
	} bus_step_t;

	typedef struct {
		logic drive_low;
		logic busy;
		logic done;
		logic presence;
		logic [15:0] raw;
		logic [15:0] centi;
	} reading_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [19:0] cfg_data = 20'd0;

	onewire_temperature_reader_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Words waiting to be sent, and the readings the sequencer model predicts.
	bus_step_t bus_steps[$];
	reading_t expected_readings[$];

	int mismatches = 0;
	int readings_seen = 0;
	int random_items = 0;
	int send_gap = 0;
	int take_gap = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	int unsigned cycle_count = 0;

	// ------------------------------------------------------------------
	// Sequencer model. It keeps its own copy of the timing registers and
	// of the script position, and is stepped once per accepted word.
	// ------------------------------------------------------------------
	cfg_t timing;
	phase_t seq_phase = PH_IDLE;
	logic [19:0] seq_ticks = '0;
	logic [3:0] seq_bit = '0;
	logic [7:0] seq_cmd = '0;
	logic [15:0] seq_rx = '0;
	logic seq_pres = 1'b0;
	logic [15:0] seq_centi = '0;
	logic seq_fin = 1'b0;

	// Ticks spent in a phase; a command bit slot depends on the bit being sent.
	function automatic logic [19:0] ticks_in(phase_t p);
		logic [19:0] n;
		case (p)
			PH_RST1_LOW, PH_RST2_LOW: n = 20'(timing.reset_low_ticks);
			PH_RST1_WAIT, PH_RST2_WAIT: begin
				// The presence window never collapses to nothing.
				n = (timing.presence_sample_ticks == 0) ? 20'd1 : 20'(timing.presence_sample_ticks);
			end
			PH_RST1_REC, PH_RST2_REC: n = 20'(timing.reset_recovery_ticks);
			PH_CC1_LOW, PH_CNV_LOW, PH_CC2_LOW, PH_BE_LOW: begin
				n = seq_cmd[0] ? 20'd1 : 20'(timing.slot_ticks);
			end
			PH_CC1_REL, PH_CNV_REL, PH_CC2_REL, PH_BE_REL: begin
				n = seq_cmd[0] ? 20'(timing.slot_ticks) : 20'(timing.zero_recovery_ticks);
			end
			PH_CONV_WAIT: n = timing.conversion_wait_ticks;
			PH_RX_REL: n = 20'(timing.slot_ticks) + 20'd1;
			default: n = 20'd1;
		endcase
		return n;
	endfunction

	// Report the scratchpad word and convert sixteenths of a degree to
	// hundredths; integer division in SystemVerilog truncates toward zero.
	task automatic close_reading();
		int centi_full;
		centi_full = int'($signed(seq_rx)) * 100 / 16;
		seq_centi = centi_full[15:0];
		seq_fin = 1'b1;
		seq_phase = PH_IDLE;
	endtask

	// Step out of the current phase into the next one of the script.
	task automatic leave_phase(input logic level);
		case (seq_phase)
			PH_RST1_WAIT: begin
				seq_pres = level;
				seq_phase = PH_RST1_REC;
			end
			PH_RST2_WAIT: begin
				seq_pres = level;
				seq_phase = PH_RST2_REC;
			end
			PH_RST1_REC, PH_RST2_REC: begin
				seq_cmd = CMD_SKIP_ROM;
				seq_bit = 4'd0;
				seq_phase = (seq_phase == PH_RST1_REC) ? PH_CC1_LOW : PH_CC2_LOW;
			end
			PH_CC1_REL, PH_CNV_REL, PH_CC2_REL, PH_BE_REL: begin
				seq_cmd = seq_cmd >> 1;
				seq_bit = seq_bit + 4'd1;
				if (seq_bit != 4'd8) begin
					case (seq_phase)
						PH_CC1_REL: seq_phase = PH_CC1_LOW;
						PH_CNV_REL: seq_phase = PH_CNV_LOW;
						PH_CC2_REL: seq_phase = PH_CC2_LOW;
						default: seq_phase = PH_BE_LOW;
					endcase
				end else begin
					// A whole command byte has gone out.
					seq_bit = 4'd0;
					case (seq_phase)
						PH_CC1_REL: begin
							seq_cmd = CMD_CONVERT;
							seq_phase = PH_CNV_LOW;
						end
						PH_CNV_REL: seq_phase = PH_CONV_WAIT;
						PH_CC2_REL: begin
							seq_cmd = CMD_READ_PAD;
							seq_phase = PH_BE_LOW;
						end
						default: begin
							seq_rx = 16'd0;
							seq_phase = PH_RX_LOW;
						end
					endcase
				end
			end
			PH_CONV_WAIT: seq_phase = PH_RST2_LOW;
			PH_RX_REL: begin
				if (seq_bit == 4'd15) begin
					close_reading();
				end else begin
					seq_bit = seq_bit + 4'd1;
					seq_phase = PH_RX_LOW;
				end
			end
			PH_RST1_LOW: seq_phase = PH_RST1_WAIT;
			PH_CC1_LOW: seq_phase = PH_CC1_REL;
			PH_CNV_LOW: seq_phase = PH_CNV_REL;
			PH_RST2_LOW: seq_phase = PH_RST2_WAIT;
			PH_CC2_LOW: seq_phase = PH_CC2_REL;
			PH_BE_LOW: seq_phase = PH_BE_REL;
			PH_RX_LOW: seq_phase = PH_RX_REL;
			default: seq_phase = PH_IDLE;
		endcase
		seq_ticks = 20'd0;
	endtask

	// Phases of zero length are passed over within the same word.
	task automatic skip_empty(input logic level);
		while (seq_phase != PH_IDLE && ticks_in(seq_phase) == 20'd0) begin
			leave_phase(level);
		end
	endtask

	task automatic step_sequencer(input logic op, input logic level, output reading_t r);
		seq_fin = 1'b0;
		if (op == OP_START) begin
			// A start while a measurement runs is dropped and does not count as a tick.
			if (seq_phase == PH_IDLE) begin
				seq_phase = PH_RST1_LOW;
				seq_ticks = 20'd0;
				skip_empty(level);
			end
		end else if (seq_phase != PH_IDLE) begin
			// The read bit is the level of the first released tick of the slot.
			if (seq_phase == PH_RX_REL && seq_ticks == 20'd0) begin
				seq_rx[seq_bit] = seq_rx[seq_bit] | level;
			end
			seq_ticks = seq_ticks + 20'd1;
			if (seq_ticks >= ticks_in(seq_phase)) begin
				leave_phase(level);
				skip_empty(level);
			end
		end
		r.drive_low = seq_phase inside {PH_RST1_LOW, PH_RST2_LOW, PH_CC1_LOW, PH_CNV_LOW,
			PH_CC2_LOW, PH_BE_LOW, PH_RX_LOW};
		r.busy = (seq_phase != PH_IDLE);
		r.done = seq_fin;
		r.presence = seq_pres;
		// Outside the completing word both value fields read as zero.
		r.raw = seq_fin ? seq_rx : 16'd0;
		r.centi = seq_fin ? seq_centi : 16'd0;
	endtask

	// ------------------------------------------------------------------
	// Idling on both sides: usually short gaps, now and then a long one,
	// and stretches where a side never idles at all.
	// ------------------------------------------------------------------
	function automatic int pick_pause(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Sender: holds a word until it is taken, then fetches the next one from
	// the pending queue after an optional gap. The model is stepped at the
	// edge at which the word is accepted.
	always @(posedge clk) begin : drive_side
		bus_step_t nxt;
		reading_t r;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				step_sequencer(s_tuser[0], s_tdata[0], r);
				expected_readings.push_back(r);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0 || bus_steps.size() == 0) begin
					if (send_gap > 0) begin
						send_gap--;
					end
					s_tvalid <= 1'b0;
				end else begin
					nxt = bus_steps.pop_front();
					s_tuser <= nxt.op;
					s_tdata <= {7'd0, nxt.level};
					s_tvalid <= 1'b1;
					send_gap = pick_pause(send_calm);
				end
			end
			if ($urandom_range(0, 399) == 0) begin
				send_calm = !send_calm;
			end
		end
	end

	// Once in the run the receiver refuses results for a long stretch while
	// the sender still has words queued, so the unit backs up into its input.
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && readings_seen > 100 && bus_steps.size() > 8) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end
	end

	always @(posedge clk) begin : take_side
		if (arst_n) begin
			if (holdoff_left > 0) begin
				m_tready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				take_gap = pick_pause(take_calm);
			end
			if ($urandom_range(0, 399) == 0) begin
				take_calm = !take_calm;
			end
		end
	end

	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Monitor: every result word is matched against the oldest prediction.
	always @(posedge clk) begin : watch_side
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			readings_seen++;
			if (expected_readings.size() == 0) begin
				$display("%0t ns: result word %h arrived with none expected, expected nothing",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				check_field("drive_low", 16'(want.drive_low), 16'(m_tdata[0]));
				check_field("busy_res", 16'(want.busy), 16'(m_tdata[1]));
				check_field("done_res", 16'(want.done), 16'(m_tdata[2]));
				check_field("presence_seen", 16'(want.presence), 16'(m_tdata[3]));
				check_field("raw_reading", want.raw, m_tdata[19:4]);
				check_field("temperature_centi", want.centi, m_tdata[35:20]);
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("onewire_temperature_reader_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------
	task automatic write_timing(input logic [2:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_RESET_LOW: timing.reset_low_ticks = val[11:0];
			REG_PRESENCE_SAMP: timing.presence_sample_ticks = val[11:0];
			REG_RESET_REC: timing.reset_recovery_ticks = val[11:0];
			REG_SLOT: timing.slot_ticks = val[7:0];
			REG_ZERO_REC: timing.zero_recovery_ticks = val[7:0];
			REG_CONV_WAIT: timing.conversion_wait_ticks = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input int rst_low, input int pres, input int rst_rec,
		input int slot, input int zero_rec, input int conv);
		write_timing(REG_RESET_LOW, 20'(rst_low));
		write_timing(REG_PRESENCE_SAMP, 20'(pres));
		write_timing(REG_RESET_REC, 20'(rst_rec));
		write_timing(REG_SLOT, 20'(slot));
		write_timing(REG_ZERO_REC, 20'(zero_rec));
		write_timing(REG_CONV_WAIT, 20'(conv));
	endtask

	// Waits until every word has been sent and every result has come back.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (bus_steps.size() != 0 || s_tvalid || expected_readings.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Queues a batch of words: mostly ticks, with a stray start at the given
	// odds (zero for none), and the bus level following the chosen mode.
	task automatic push_steps(input int count, input int start_odds, input level_mode_t mode);
		bus_step_t st;
		level_mode_t m;
		m = mode;
		if (m == LEVEL_MIXED) begin
			m = level_mode_t'($urandom_range(0, 3));
		end
		for (int i = 0; i < count; i++) begin
			st.op = (start_odds > 0 && $urandom_range(0, start_odds - 1) == 0) ? OP_START : OP_TICK;
			case (m)
				LEVEL_LOW: st.level = 1'b0;
				LEVEL_HIGH: st.level = 1'b1;
				LEVEL_MOSTLY_HIGH: st.level = ($urandom_range(0, 7) != 0);
				default: st.level = 1'($urandom_range(0, 1));
			endcase
			bus_steps.push_back(st);
			random_items++;
		end
	endtask

	// A start followed by ticks until the model reports the sequencer idle
	// again. Stray starts in the batches may kick off further measurements,
	// which are also run to completion.
	task automatic run_measurement(input level_mode_t mode, input int start_odds);
		bus_step_t st;
		st.op = OP_START;
		st.level = 1'($urandom_range(0, 1));
		bus_steps.push_back(st);
		do begin
			push_steps(CHUNK, start_odds, mode);
			wait_drained();
		end while (seq_phase != PH_IDLE);
	endtask

	// Mostly very short timings so that many measurements fit into the run.
	function automatic int pick_ticks();
		int r;
		r = $urandom_range(0, 15);
		if (r < 3) begin
			return 0;
		end else if (r < 14) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	initial begin
		bus_step_t st;
		timing.reset_low_ticks = 12'd500;
		timing.presence_sample_ticks = 12'd30;
		timing.reset_recovery_ticks = 12'd500;
		timing.slot_ticks = 8'd80;
		timing.zero_recovery_ticks = 8'd8;
		timing.conversion_wait_ticks = 20'd800000;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ticks while idle change nothing and leave the line released.
		st.op = OP_TICK;
		st.level = 1'b0;
		bus_steps.push_back(st);
		st.level = 1'b1;
		bus_steps.push_back(st);
		wait_drained();

		// All timings zero: empty phases are skipped within one word and the
		// presence window is stretched to one tick. A high bus reads back
		// as -1, a low bus as 0; starts arrive while the script runs.
		set_timing(0, 0, 0, 0, 0, 0);
		run_measurement(LEVEL_HIGH, 8);
		run_measurement(LEVEL_LOW, 8);

		// A distinct short timing on every register, so that a register
		// feeding the wrong phase shows up; the run stays bounded.
		set_timing(7, 5, 9, 3, 2, 6);
		run_measurement(LEVEL_RANDOM, 0);
		write_timing(REG_CONV_WAIT, 20'hFFFFF);

		// Random timings and bus behavior, with stray starts and idle ticks.
		random_items = 0;
		while (random_items < 300) begin
			set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
				pick_ticks());
			run_measurement(LEVEL_MIXED, 16);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("onewire_temperature_reader_unit: match");
		end else begin
			$display("onewire_temperature_reader_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/owr_pkg.sv
design/owr_core.sv
design/onewire_temperature_reader_unit.sv
tb/sv/tb_top.sv
